FILE: rtl/tcws_pkg.sv
// Shared types and constants for the tick counter wake-up scheduler.
// Has no dependencies. The scheduler core and the top level import it.
package tcws_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned OvfW  = 48;
  localparam int unsigned TimeW = CntW + OvfW;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SCHED = 2'd2
  } cmd_e;

  // Latency class returned by a schedule
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_HIGH = 2'd2
  } cls_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_NOW_THR   = 2'd0;
  localparam logic [1:0] CFG_SLEEP_LAT = 2'd1;
  localparam logic [1:0] CFG_WAKE_LAT  = 2'd2;

  // Configuration reset values
  localparam logic [CntW-1:0] NowThrRst   = 16'd5;
  localparam logic [CntW-1:0] SleepLatRst = 16'd100;
  localparam logic [CntW-1:0] WakeLatRst  = 16'd50;

  // Configuration register set
  typedef struct packed {
    logic [CntW-1:0] now_thr;
    logic [CntW-1:0] sleep_lat;
    logic [CntW-1:0] wake_lat;
  } cfg_t;

  // Schedule decision handed back to the top level
  typedef struct packed {
    cls_e            cls;
    logic            disarm;
    logic            arm;
    logic [CntW-1:0] arm_val;
  } sched_t;

endpackage

FILE: rtl/tcws_sched.sv
// Schedule decision logic: target minus current time, class and compare value.
// Depends on tcws_pkg. Pure combinational, used by tick_counter_wakeup_scheduler.
module tcws_sched (
  input  logic [tcws_pkg::TimeW-1:0] target_i,
  input  logic [tcws_pkg::TimeW-1:0] now_i,
  input  logic [tcws_pkg::CntW-1:0]  low_count_i,
  input  logic                       sleep_veto_i,
  input  tcws_pkg::cfg_t             cfg_i,
  output tcws_pkg::sched_t           sched_o
);
  import tcws_pkg::*;

  logic [TimeW-1:0] diff;
  logic             neg;
  logic             hi_zero16;
  logic             hi_zero17;
  logic             below_thr;
  logic [CntW:0]    lat_sum;
  logic             below_lat;
  logic [CntW:0]    v_low;
  logic             fits_low;
  logic [CntW+2:0]  v_high;
  logic             fits_high;

  // Distance to the deadline, signed
  assign diff      = target_i - now_i;
  assign neg       = diff[TimeW-1];
  assign hi_zero16 = (diff[TimeW-1:CntW] == '0);
  assign hi_zero17 = (diff[TimeW-1:CntW+1] == '0);

  assign below_thr = hi_zero16 && (diff[CntW-1:0] < cfg_i.now_thr);
  assign lat_sum   = {1'b0, cfg_i.sleep_lat} + {1'b0, cfg_i.wake_lat};
  assign below_lat = hi_zero17 && (diff[CntW:0] < lat_sum);

  // Exact compare point
  assign v_low    = {1'b0, diff[CntW-1:0]} + {1'b0, low_count_i};
  assign fits_low = hi_zero16 && !v_low[CntW];

  // Early compare point; diff >= wake latency on this branch, so no underflow
  assign v_high    = {2'b00, diff[CntW:0]} + {3'b000, low_count_i}
                   - {3'b000, cfg_i.wake_lat};
  assign fits_high = hi_zero17 && (v_high[CntW+2:CntW] == 3'b000);

  always_comb begin
    sched_o = '{cls: CLS_NONE, disarm: 1'b0, arm: 1'b0, arm_val: '0};
    if (neg || below_thr) begin
      sched_o.disarm = 1'b1;
    end else if (below_lat || sleep_veto_i) begin
      sched_o.cls     = CLS_LOW;
      sched_o.arm     = fits_low;
      sched_o.arm_val = v_low[CntW-1:0];
    end else begin
      sched_o.cls     = CLS_HIGH;
      sched_o.arm     = fits_high;
      sched_o.arm_val = v_high[CntW-1:0];
    end
  end

endmodule

FILE: rtl/tick_counter_wakeup_scheduler.sv
// Extended 64-bit tick counter with wake-up compare: top level.
// Depends on tcws_pkg and tcws_sched.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | command, target_time, sleep_veto
//   out     | output    | out_valid_o/out_stall_i| current_time, latency_class, armed, fire
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// An item passes the input register, then one pass of the command logic
// into the result register. One item per cycle is sustained while the
// result is not stalled; the counter state loop (64-bit subtract plus
// compare into the state registers) sets it. Reset clears the count, the
// compare and both pipeline stages and loads the configuration defaults.
// A stalled result holds the pipeline; an empty input register still fills.
module tick_counter_wakeup_scheduler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [tcws_pkg::TimeW-1:0] target_time_i,
  input  logic                       sleep_veto_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcws_pkg::TimeW-1:0] current_time_o,
  output logic [1:0]                 latency_class_o,
  output logic                       compare_armed_o,
  output logic                       wakeup_fire_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [tcws_pkg::CntW-1:0]  cfg_data_i
);
  import tcws_pkg::*;

  // input stage
  logic             s1_valid_q;
  logic [1:0]       cmd_q;
  logic [TimeW-1:0] target_q;
  logic             blocked_q;

  // result stage
  logic             out_valid_q;
  logic [TimeW-1:0] time_q;
  logic [1:0]       cls_q;
  logic             armed_q;
  logic             fire_q;

  // counter state
  logic [CntW-1:0]  low_q, low_d;
  logic [OvfW-1:0]  ovf_q, ovf_d;
  logic [CntW-1:0]  cmp_q, cmp_d;
  logic             en_q, en_d;
  cfg_t             cfg_q;

  logic             out_free;
  logic             adv;
  logic             in_acc;
  logic             fire_d;
  cls_e             cls_d;
  sched_t           sched;

  // handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{now_thr: NowThrRst, sleep_lat: SleepLatRst, wake_lat: WakeLatRst};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NOW_THR:   cfg_q.now_thr   <= cfg_data_i;
        CFG_SLEEP_LAT: cfg_q.sleep_lat <= cfg_data_i;
        CFG_WAKE_LAT:  cfg_q.wake_lat  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= command_i;
      target_q  <= target_time_i;
      blocked_q <= sleep_veto_i;
    end
  end

  tcws_sched u_sched (
    .target_i     (target_q),
    .now_i        ({ovf_q, low_q}),
    .low_count_i  (low_q),
    .sleep_veto_i (blocked_q),
    .cfg_i        (cfg_q),
    .sched_o      (sched)
  );

  // command execution
  always_comb begin
    low_d  = low_q;
    ovf_d  = ovf_q;
    cmp_d  = cmp_q;
    en_d   = en_q;
    fire_d = 1'b0;
    cls_d  = CLS_NONE;
    unique case (cmd_q)
      CMD_TICK: begin
        low_d = low_q + 1'b1;
        if (low_d == '0) begin
          ovf_d = ovf_q + 1'b1;
        end
        fire_d = en_q && (low_d == cmp_q);
      end
      CMD_SCHED: begin
        cls_d = sched.cls;
        if (sched.disarm) begin
          en_d = 1'b0;
        end else if (sched.arm) begin
          en_d  = 1'b1;
          cmp_d = sched.arm_val;
        end
      end
      default: ; // read, and the unused code, leave state alone
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      ovf_q       <= '0;
      cmp_q       <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        low_q       <= low_d;
        ovf_q       <= ovf_d;
        cmp_q       <= cmp_d;
        en_q        <= en_d;
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      time_q  <= {ovf_d, low_d};
      cls_q   <= cls_d;
      armed_q <= en_d;
      fire_q  <= fire_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_time_o  = time_q;
  assign latency_class_o = cls_q;
  assign compare_armed_o = armed_q;
  assign wakeup_fire_o   = fire_q;

  // a match is only reported while the compare is armed
  a_fire_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wakeup_fire_o |-> compare_armed_o)
    else $error("wakeup fire without armed compare");

  // a schedule of class none leaves the compare disarmed
  a_none_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (cmd_q == CMD_SCHED) && (sched.cls == CLS_NONE) |=> !en_q)
    else $error("class none did not disarm compare");

  // only a tick moves the time
  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (cmd_q != CMD_TICK) |=> ({ovf_q, low_q} == $past({ovf_q, low_q})))
    else $error("time changed on a non-tick item");

endmodule
